FILE: rtl/bfr_pkg.sv
`default_nettype none
package bfr_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] coord_x;
      logic [7:0] coord_y;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       out_of_range;
   } rsp_type;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_COMPUTE = 2'd1;
   localparam logic [1:0] KIND_OOR     = 2'd2;

   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DST_HEIGHT = 2'd3;

   localparam int DIVIDEND_W = 24;
   localparam int DIVISOR_W  = 17;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  coord_x;
      logic [7:0]  coord_y;
      logic [31:0] pixel;
   } work_type;

   typedef struct packed {
      logic     avail;
      work_type work;
   } queue_type;

endpackage
`default_nettype wire

FILE: rtl/bfr_front.sv
`default_nettype none
module bfr_front
   import bfr_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 64,
   parameter int MAX_SRC_HEIGHT = 64
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_push,
   output logic           req_full,
   input  wire req_type   req_data,
   input  wire logic [7:0] dst_width,
   input  wire logic [7:0] dst_height,
   output queue_type      q_out,
   input  wire logic      q_pop
);

   work_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept, enq, deq, in_store;
   work_type   item;

   assign req_full = (cnt_ff == 2'd2);
   assign accept   = req_push && !req_full;
   assign in_store = ({1'b0, req_data.coord_x} < 9'(MAX_SRC_WIDTH))
                  && ({1'b0, req_data.coord_y} < 9'(MAX_SRC_HEIGHT));

   always_comb begin
      item.coord_x = req_data.coord_x;
      item.coord_y = req_data.coord_y;
      item.pixel   = {req_data.in_alpha, req_data.in_blue, req_data.in_green, req_data.in_red};
      if (req_data.command == CMD_LOAD) begin
         item.kind = KIND_LOAD;
      end else if (req_data.coord_x >= dst_width || req_data.coord_y >= dst_height) begin
         item.kind = KIND_OOR;
      end else begin
         item.kind = KIND_COMPUTE;
      end
   end

   // Loads that fall outside the store are taken and dropped.
   assign enq = accept && !(req_data.command == CMD_LOAD && !in_store);
   assign deq = q_pop && (cnt_ff != 2'd0);

   assign q_out.avail = (cnt_ff != 2'd0);
   assign q_out.work  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(enq) - 2'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (enq) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/bfr_div.sv
`default_nettype none
module bfr_div
   import bfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // One restoring step a cycle, most significant bit first.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = trial >= {1'b0, div_ff};
      rem_in  = fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
      quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
      cnt_in  = cnt_ff - CNT_W'(1);
      busy_in = busy_ff && (cnt_ff != CNT_W'(1));
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start ? 1'b1 : busy_in;
         done_ff <= start ? 1'b0 : done_in;
      end
      if (start) begin
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= dividend;
         cnt_ff <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/bfr_back.sv
`default_nettype none
module bfr_back
   import bfr_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 64,
   parameter int MAX_SRC_HEIGHT = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire queue_type  q_in,
   output logic            q_pop,
   input  wire logic [6:0] src_width,
   input  wire logic [6:0] src_height,
   input  wire logic [7:0] dst_width,
   input  wire logic [7:0] dst_height,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data
);

   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BND   = 3'd1;
   localparam logic [2:0] S_CLIP  = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_AVG   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [31:0] mem [DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [7:0]  x_ff, y_ff;
   logic [1:0]  idx_ff, idx_in;
   logic        go_ff, go_in;
   logic [8:0]  bnd_ff [4];
   logic [8:0]  ix_ff, ix_in, iy_ff, iy_in;
   logic [8:0]  x0_ff, x1_ff, y1_ff;
   logic [23:0] sum_ff [4];
   logic [16:0] count_ff;
   logic        rd_pend_ff, rd_pend_in;
   logic [31:0] rd_data_ff;
   logic [7:0]  avg_ff [4];
   logic        oor_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [8:0]  sw, sh, mul_a, mul_b, x1w, y1w, x1c, y1c;
   logic [17:0] product;
   logic [23:0] dividend;
   logic [16:0] divisor;
   logic        div_done;
   logic [23:0] quotient;
   logic        rd_en, wr_en, clip_go, walk_last;
   logic [AW-1:0] rd_addr, wr_addr;

   assign sw = (9'(src_width) > 9'(MAX_SRC_WIDTH))  ? 9'(MAX_SRC_WIDTH)  : 9'(src_width);
   assign sh = (9'(src_height) > 9'(MAX_SRC_HEIGHT)) ? 9'(MAX_SRC_HEIGHT) : 9'(src_height);

   // Box bounds x0, x1, y0, y1 come out of the shared divider in that order.
   always_comb begin
      unique case (idx_ff)
         2'd0:    begin mul_a = 9'(x_ff);          mul_b = sw; end
         2'd1:    begin mul_a = 9'(x_ff) + 9'd1;   mul_b = sw; end
         2'd2:    begin mul_a = 9'(y_ff);          mul_b = sh; end
         default: begin mul_a = 9'(y_ff) + 9'd1;   mul_b = sh; end
      endcase
      product = 18'(mul_a) * 18'(mul_b);
      if (state_ff == S_AVG) begin
         dividend = sum_ff[idx_ff];
         divisor  = count_ff;
      end else begin
         dividend = 24'(product);
         divisor  = (idx_ff[1]) ? 17'(dst_height) : 17'(dst_width);
      end
   end

   bfr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // Widen an empty box to one pixel, then clip to the source edge.
   always_comb begin
      x1w     = (bnd_ff[1] <= bnd_ff[0]) ? bnd_ff[0] + 9'd1 : bnd_ff[1];
      y1w     = (bnd_ff[3] <= bnd_ff[2]) ? bnd_ff[2] + 9'd1 : bnd_ff[3];
      x1c     = (x1w > sw) ? sw : x1w;
      y1c     = (y1w > sh) ? sh : y1w;
      clip_go = (bnd_ff[0] < x1c) && (bnd_ff[2] < y1c);
   end

   assign walk_last = (ix_ff + 9'd1 == x1_ff) && (iy_ff + 9'd1 == y1_ff);
   assign rd_en     = (state_ff == S_WALK);
   assign rd_addr   = AW'(18'(ix_ff) + 18'(MAX_SRC_WIDTH) * 18'(iy_ff));
   assign wr_addr   = AW'(18'(q_in.work.coord_x) + 18'(MAX_SRC_WIDTH) * 18'(q_in.work.coord_y));
   assign q_pop     = (state_ff == S_IDLE) && q_in.avail;
   assign wr_en     = q_pop && (q_in.work.kind == KIND_LOAD);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      go_in      = 1'b0;
      ix_in      = ix_ff;
      iy_in      = iy_ff;
      rd_pend_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = 2'd0;
            if (q_in.avail) begin
               priority case (q_in.work.kind)
                  KIND_COMPUTE: begin
                     state_in = S_BND;
                     go_in    = 1'b1;
                  end
                  KIND_OOR: state_in = S_DONE;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_BND: begin
            if (div_done) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = S_CLIP;
               end else begin
                  go_in = 1'b1;
               end
            end
         end
         S_CLIP: begin
            ix_in  = bnd_ff[0];
            iy_in  = bnd_ff[2];
            idx_in = 2'd0;
            state_in = clip_go ? S_WALK : S_DONE;
         end
         S_WALK: begin
            rd_pend_in = 1'b1;
            if (ix_ff + 9'd1 == x1_ff) begin
               ix_in = x0_ff;
               iy_in = iy_ff + 9'd1;
            end else begin
               ix_in = ix_ff + 9'd1;
            end
            if (walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_AVG;
            go_in    = 1'b1;
         end
         S_AVG: begin
            if (div_done) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = S_DONE;
               end else begin
                  go_in = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 2'd0;
         go_ff        <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         go_ff      <= go_in;
         rd_pend_ff <= rd_pend_in;
         if (state_ff == S_DONE && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (wr_en) begin
         mem[wr_addr] <= q_in.work.pixel;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end

      ix_ff <= ix_in;
      iy_ff <= iy_in;

      if (q_pop) begin
         x_ff   <= q_in.work.coord_x;
         y_ff   <= q_in.work.coord_y;
         oor_ff <= (q_in.work.kind == KIND_OOR);
         for (int c = 0; c < 4; c++) begin
            avg_ff[c] <= '0;
         end
      end
      if (state_ff == S_BND && div_done) begin
         bnd_ff[idx_ff] <= quotient[8:0];
      end
      if (state_ff == S_CLIP) begin
         x0_ff    <= bnd_ff[0];
         x1_ff    <= x1c;
         y1_ff    <= y1c;
         count_ff <= '0;
         for (int c = 0; c < 4; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (rd_pend_ff) begin
         count_ff <= count_ff + 17'd1;
         for (int c = 0; c < 4; c++) begin
            sum_ff[c] <= sum_ff[c] + 24'(rd_data_ff[8*c +: 8]);
         end
      end
      if (state_ff == S_AVG && div_done) begin
         avg_ff[idx_ff] <= quotient[7:0];
      end
      if (state_ff == S_DONE && !rsp_valid_ff) begin
         rsp_ff.out_red      <= avg_ff[0];
         rsp_ff.out_green    <= avg_ff[1];
         rsp_ff.out_blue     <= avg_ff[2];
         rsp_ff.out_alpha    <= avg_ff[3];
         rsp_ff.out_of_range <= oor_ff;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/box_filter_image_resampler.sv
`default_nettype none
// A load beat is written into the image store once the back end takes it; no result.
// A compute beat holds the back end while it takes the beat, gets the box bounds from the
// single serial divider and clips; if the box is not empty it walks it, drains the store
// read and averages the four channels on the same divider, then fills the output register
// once free. An out-of-range beat only fills that register. Reset is synchronous and active
// high; it empties both queues and restores the size registers; the image store keeps its data.
module box_filter_image_resampler
   import bfr_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 64,
   parameter int MAX_SRC_HEIGHT = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire req_type    req_data,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_index,
   input  wire logic [7:0] csr_data
);

   // Size registers. Writes to an index past the last register are dropped.
   logic [6:0] src_width_ff, src_height_ff;
   logic [7:0] dst_width_ff, dst_height_ff;
   queue_type  q;
   logic       q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 7'd64;
         src_height_ff <= 7'd64;
         dst_width_ff  <= 8'd64;
         dst_height_ff <= 8'd64;
      end else if (csr_valid && csr_ready && csr_index[7:2] == 6'd0) begin
         unique case (csr_index[1:0])
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[6:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[6:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            default:        dst_height_ff <= dst_height_ff;
         endcase
      end
   end

   // The front end takes beats, sorts them into loads, computes and
   // out-of-range requests, and parks them in a short queue.
   bfr_front #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .dst_width  (dst_width_ff),
      .dst_height (dst_height_ff),
      .q_out      (q),
      .q_pop      (q_pop)
   );

   // The back end owns the image store, walks each box and averages it,
   // holding its result in an output register until it is popped.
   bfr_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_in       (q),
      .q_pop      (q_pop),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .dst_width  (dst_width_ff),
      .dst_height (dst_height_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

FILE: verif/tb_box_filter_image_resampler.sv
`default_nettype none
module tb_box_filter_image_resampler;
   import bfr_pkg::*;

   localparam int SRC_MAX   = 64;
   localparam int FILL_SIDE = 20;
   localparam int RAND_BEATS = 700;
   localparam int STALL_LIMIT = 20000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   req_type    req_data = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   always #5 clock = ~clock;

   box_filter_image_resampler dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // The testbench's own copy of the image store and the size registers.
   logic [31:0] image_copy [0:SRC_MAX*SRC_MAX-1];
   bit          written    [0:SRC_MAX*SRC_MAX-1];
   logic [6:0]  src_w, src_h;
   logic [7:0]  dst_w, dst_h;

   rsp_type pixels_due[$];
   int      fail_count = 0;
   int      idle_cycles = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   // Box average of one destination pixel, as the block should compute it.
   // The hole flag is raised when the box reaches a pixel never loaded.
   function automatic rsp_type average_box(input logic [7:0] dx, input logic [7:0] dy,
                                           output bit hole);
      rsp_type r;
      int sw, sh, x0, x1, y0, y1, n, idx;
      int sum [4];
      r = '0;
      hole = 1'b0;
      sum = '{0, 0, 0, 0};
      if (dx >= dst_w || dy >= dst_h) begin
         r.out_of_range = 1'b1;
         return r;
      end
      sw = (src_w > SRC_MAX) ? SRC_MAX : src_w;
      sh = (src_h > SRC_MAX) ? SRC_MAX : src_h;
      x0 = dx * sw / dst_w;
      x1 = (dx + 1) * sw / dst_w;
      y0 = dy * sh / dst_h;
      y1 = (dy + 1) * sh / dst_h;
      if (x1 <= x0) x1 = x0 + 1;
      if (y1 <= y0) y1 = y0 + 1;
      if (x1 > sw) x1 = sw;
      if (y1 > sh) y1 = sh;
      n = 0;
      for (int iy = y0; iy < y1; iy++) begin
         for (int ix = x0; ix < x1; ix++) begin
            idx = ix + SRC_MAX*iy;
            if (!written[idx]) hole = 1'b1;
            for (int c = 0; c < 4; c++) sum[c] += image_copy[idx][8*c +: 8];
            n++;
         end
      end
      if (n > 0) begin
         r.out_red   = 8'(sum[0] / n);
         r.out_green = 8'(sum[1] / n);
         r.out_blue  = 8'(sum[2] / n);
         r.out_alpha = 8'(sum[3] / n);
      end
      return r;
   endfunction

   // Mostly short gaps, now and then a long one, and often none at all.
   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Sends one beat and records what it should give back. The push stays
   // high between beats sent back to back.
   task automatic send_beat(input req_type b, input bit typed_in, input rsp_type typed_rsp);
      int g;
      bit hole;
      rsp_type want;
      g = gap_length();
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_full);
      if (b.command == CMD_LOAD) begin
         if (b.coord_x < SRC_MAX && b.coord_y < SRC_MAX) begin
            image_copy[b.coord_x + SRC_MAX*b.coord_y] = {b.in_alpha, b.in_blue,
                                                        b.in_green, b.in_red};
            written[b.coord_x + SRC_MAX*b.coord_y] = 1'b1;
         end
      end else begin
         want = average_box(b.coord_x, b.coord_y, hole);
         if (hole) report_mismatch("stimulus box reaches a pixel never loaded");
         if (typed_in) want = typed_rsp;
         pixels_due = {pixels_due, want};
      end
   endtask

   task automatic write_register(input logic [7:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SRC_WIDTH:  src_w = val[6:0];
         CSR_SRC_HEIGHT: src_h = val[6:0];
         CSR_DST_WIDTH:  dst_w = val;
         CSR_DST_HEIGHT: dst_h = val;
         default: ;
      endcase
   endtask

   // Registers may change only once the block has drained; loads give no
   // result, so a further pause covers a load still being written.
   task automatic drain_block();
      req_push  <= 1'b0;
      csr_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
      drain_block();
      write_register(8'(CSR_SRC_WIDTH), 8'(sw));
      write_register(8'(CSR_SRC_HEIGHT), 8'(sh));
      write_register(8'(CSR_DST_WIDTH), 8'(dw));
      write_register(8'(CSR_DST_HEIGHT), 8'(dh));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type load_beat(input int x, input int y);
      req_type b;
      b = {CMD_LOAD, x[7:0], y[7:0], 32'($urandom)};
      return b;
   endfunction

   function automatic req_type compute_beat(input int x, input int y);
      req_type b;
      b = {CMD_COMPUTE, x[7:0], y[7:0], 32'($urandom)};
      return b;
   endfunction

   // Result side: pops with random stalls and checks against the oldest entry.
   initial begin : result_side
      rsp_type want;
      int g;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pixels_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_data));
            end else begin
               want = pixels_due.pop_front();
               if (rsp_data.out_red !== want.out_red)
                  report_mismatch($sformatf("red %h want %h", rsp_data.out_red, want.out_red));
               if (rsp_data.out_green !== want.out_green)
                  report_mismatch($sformatf("green %h want %h", rsp_data.out_green,
                                            want.out_green));
               if (rsp_data.out_blue !== want.out_blue)
                  report_mismatch($sformatf("blue %h want %h", rsp_data.out_blue,
                                            want.out_blue));
               if (rsp_data.out_alpha !== want.out_alpha)
                  report_mismatch($sformatf("alpha %h want %h", rsp_data.out_alpha,
                                            want.out_alpha));
               if (rsp_data.out_of_range !== want.out_of_range)
                  report_mismatch($sformatf("range flag %b want %b", rsp_data.out_of_range,
                                            want.out_of_range));
            end
         end
         g = gap_length();
         if (g == 0) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= 1'b0;
            repeat (g) @(posedge clock);
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   initial begin : stimulus
      stim_row_type rows [10];
      rsp_type zero_rsp, oor_rsp;
      req_type b;
      int sw, sh, dw, dh, kind;
      zero_rsp = '0;
      oor_rsp = '0;
      oor_rsp.out_of_range = 1'b1;
      src_w = 7'd64; src_h = 7'd64; dst_w = 8'd64; dst_h = 8'd64;
      for (int i = 0; i < SRC_MAX*SRC_MAX; i++) begin
         image_copy[i] = '0;
         written[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load the top left corner and the first two full rows, so that no box
      // used below reaches a pixel never loaded; the extremes of every channel
      // sit in the two far corners.
      for (int y = 0; y < FILL_SIDE; y++) begin
         for (int x = 0; x < SRC_MAX; x++) begin
            if (y < 2 || x < FILL_SIDE) begin
               b = load_beat(x, y);
               if (x == 0 && y == 0) {b.in_red, b.in_green, b.in_blue, b.in_alpha} = '0;
               send_beat(b, 1'b0, zero_rsp);
            end
         end
      end
      b = load_beat(63, 63);
      {b.in_red, b.in_green, b.in_blue, b.in_alpha} = '1;
      send_beat(b, 1'b0, zero_rsp);

      // Directed table: reset sizes, one-to-one corners, out-of-range
      // destinations, ignored loads outside the store, and two boxes checked by average_box.
      rows[0] = '{compute_beat(0, 0), 1'b1, zero_rsp};
      rows[1] = '{compute_beat(63, 63), 1'b1, '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0}};
      rows[2] = '{compute_beat(64, 0), 1'b1, oor_rsp};
      rows[3] = '{compute_beat(0, 64), 1'b1, oor_rsp};
      rows[4] = '{compute_beat(255, 255), 1'b1, oor_rsp};
      rows[5] = '{load_beat(64, 3), 1'b0, zero_rsp};
      rows[6] = '{load_beat(3, 64), 1'b0, zero_rsp};
      rows[7] = '{load_beat(255, 255), 1'b0, zero_rsp};
      rows[8] = '{compute_beat(5, 7), 1'b0, zero_rsp};
      rows[9] = '{compute_beat(12, 17), 1'b0, zero_rsp};
      foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].want);

      // Source size zero gives zeros without the flag; oversized source acts
      // as the largest; a destination of zero puts every pixel out of range.
      set_sizes(0, 5, 3, 3);
      send_beat(compute_beat(1, 1), 1'b1, zero_rsp);
      set_sizes(127, 2, 1, 1);
      send_beat(compute_beat(0, 0), 1'b0, zero_rsp);
      set_sizes(64, 64, 255, 255);
      send_beat(compute_beat(254, 254), 1'b0, zero_rsp);
      send_beat(compute_beat(0, 0), 1'b0, zero_rsp);
      set_sizes(1, 1, 0, 0);
      send_beat(compute_beat(0, 0), 1'b1, oor_rsp);
      drain_block();
      write_register(8'd200, 8'h55);
      set_sizes(64, 64, 64, 64);

      // Random part, in phases of RAND_BEATS / 5 beats (the last of ten) with fresh sizes; the
      // large boxes are kept rare by using mostly upscaling destinations.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) begin
            sw = 64; sh = 2; dw = 1; dh = 1;
         end else begin
            sw = $urandom_range(1, FILL_SIDE);
            sh = $urandom_range(1, FILL_SIDE);
            if ($urandom_range(0, 3) == 0) begin
               sw = $urandom_range(65, 127);
               sh = $urandom_range(1, 2);
            end
            dw = $urandom_range(1, 255);
            dh = $urandom_range(1, 255);
         end
         set_sizes(sw, sh, dw, dh);
         for (int i = 0; i < (phase == 5 ? 10 : RAND_BEATS / 5); i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
               b = load_beat($urandom_range(0, 63), $urandom_range(0, 63));
            end else if (kind == 3) begin
               b = compute_beat($urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
               b = compute_beat($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
            end
            send_beat(b, 1'b0, zero_rsp);
         end
      end

      drain_block();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
rtl/bfr_pkg.sv
rtl/bfr_front.sv
rtl/bfr_div.sv
rtl/bfr_back.sv
rtl/box_filter_image_resampler.sv
verif/tb_box_filter_image_resampler.sv
